FILE: hdl/sjlw_pkg.sv
// Shared types, constants and sigmoid knot generation for the joint-limit weight core.
`default_nettype none

package sjlw_pkg;

  localparam int SIGMOID_SEGMENTS_DEF = 64;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] INV_DAMP_RESET    = 16'd2560;
  localparam logic [15:0] SPEED_GAIN_RESET  = 16'd256;
  localparam logic [14:0] MARGIN_RESET      = 15'd410;
  localparam logic [15:0] SPEED_OFFSET_RESET = 16'd0;

  // 1.0 in unsigned Q1.15
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INV_DAMP     = 2'd0,
    CFG_SPEED_GAIN   = 2'd1,
    CFG_MARGIN       = 2'd2,
    CFG_SPEED_OFFSET = 2'd3
  } reg_index_t;

  // Per-stage load enables of the seven-stage pipe.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } pipe_en_t;

  // Restoring divide, only used while building the knot table.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int n = 63; n >= 0; n--) begin
      rem = {rem[63:0], a[n]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[n] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-(num/den) in Q30: Taylor series of e^-(x/16), then squared four times.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] sum;
    u    = udiv64(num << 30, 64'd16 * den);
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64((term * u) >> 30, 64'(n));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (int n = 0; n < 4; n++) begin
      sum = (sum * sum) >> 30;
    end
    return sum;
  endfunction

  // Sigmoid value at knot k of nseg segments, unsigned Q1.15.
  function automatic logic [15:0] sig_knot(input int k, input int nseg);
    longint diff;
    longint t;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] p;
    diff = 16 * longint'(k) - 8 * longint'(nseg);
    t    = (diff < 0) ? -diff : diff;
    e    = exp_neg_q30(64'(t), 64'(nseg));
    d    = Q30_ONE + e;
    p    = udiv64((64'd1 << 45) + (d >> 1), d);
    return (diff < 0) ? 16'(64'd32768 - p) : 16'(p);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sjlw_arg.sv
// Stages 1-3: the three sigmoid arguments, clamped and offset to [0, 65536].
`default_nettype none

module sjlw_arg (
  input  wire logic             clk,
  input  wire sjlw_pkg::pipe_en_t en,
  input  wire logic signed [15:0] joint_position,
  input  wire logic signed [15:0] joint_velocity,
  input  wire logic signed [15:0] lower_limit,
  input  wire logic signed [15:0] upper_limit,
  input  wire logic [15:0]      inv_position_damping,
  input  wire logic [15:0]      speed_gain,
  input  wire logic [14:0]      position_margin,
  input  wire logic signed [15:0] speed_offset,
  output logic [16:0]           u_rise,
  output logic [16:0]           u_fall,
  output logic [16:0]           u_speed
);
  import sjlw_pkg::*;

  // clamp to [-8, 8] in Q.12 and shift up by 8
  function automatic logic [16:0] clamp_u(input logic signed [49:0] x);
    if (x < -50'sd32768) begin
      return 17'd0;
    end else if (x > 50'sd32768) begin
      return 17'd65536;
    end else begin
      return 17'(x + 50'sd32768);
    end
  endfunction

  logic signed [17:0] d_lo;
  logic signed [17:0] d_hi;
  logic signed [31:0] p_sp;
  logic signed [34:0] m_lo;
  logic signed [34:0] m_hi;
  logic signed [48:0] m_sp;

  logic signed [31:0] qv;
  logic signed [34:0] sh_lo;
  logic signed [34:0] sh_hi;
  logic signed [49:0] neg_sp;
  logic signed [49:0] sh_sp;

  assign qv     = joint_position * joint_velocity;
  assign sh_lo  = m_lo >>> 8;
  assign sh_hi  = m_hi >>> 8;
  assign neg_sp = -(50'(m_sp));
  assign sh_sp  = neg_sp >>> 20;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d_lo <= 18'(joint_position) - 18'(lower_limit) - $signed({3'b000, position_margin});
      d_hi <= 18'(upper_limit) - $signed({3'b000, position_margin}) - 18'(joint_position);
      p_sp <= qv + 32'($signed({speed_offset, 12'h000}));
    end
    if (en.s2) begin
      m_lo <= d_lo * $signed({1'b0, inv_position_damping});
      m_hi <= d_hi * $signed({1'b0, inv_position_damping});
      m_sp <= p_sp * $signed({1'b0, speed_gain});
    end
    if (en.s3) begin
      u_rise  <= clamp_u(50'(sh_lo));
      u_fall  <= clamp_u(50'(sh_hi));
      u_speed <= clamp_u(sh_sp);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sjlw_sigmoid.sv
// Stages 4-5: piecewise-linear sigmoid lookup from a constant knot table.
`default_nettype none

module sjlw_sigmoid #(
  parameter int SIGMOID_SEGMENTS = sjlw_pkg::SIGMOID_SEGMENTS_DEF
) (
  input  wire logic             clk,
  input  wire sjlw_pkg::pipe_en_t en,
  input  wire logic [16:0]      u,
  output logic [15:0]           s
);
  import sjlw_pkg::*;

  localparam int SEGW = $clog2(SIGMOID_SEGMENTS + 1);
  localparam int PW   = 16 + SEGW;

  logic [15:0] rom [SIGMOID_SEGMENTS + 1];

  for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_knot
    localparam logic [15:0] KNOT = sig_knot(k, SIGMOID_SEGMENTS);
    assign rom[k] = KNOT;
  end

  logic [PW-1:0]   p;
  logic [SEGW-1:0] seg;
  logic [SEGW-1:0] seg_hi;
  logic            full;
  logic [15:0]     lo_val;
  logic [15:0]     hi_val;

  logic [15:0] base;
  logic [15:0] diff;
  logic [15:0] frac;

  logic [32:0] interp;

  assign p      = PW'(u) * PW'(SIGMOID_SEGMENTS);
  assign seg    = p[PW-1:16];
  assign full   = (seg >= SEGW'(SIGMOID_SEGMENTS));
  assign seg_hi = full ? seg : seg + SEGW'(1);
  assign lo_val = rom[seg];
  assign hi_val = rom[seg_hi];
  assign interp = 33'(diff) * 33'(frac) + 33'd32768;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      base <= lo_val;
      // top knot: zero slope, so the fraction adds nothing
      diff <= full ? 16'd0 : hi_val - lo_val;
      frac <= p[15:0];
    end
    if (en.s5) begin
      s <= base + 16'(interp >> 16);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sigmoid_joint_limit_weight_core.sv
// Top level of the sigmoid joint-limit weight core: config, pipe control, final combine.
`default_nettype none

// One joint item enters per cycle while the output is not stalled. The seven
// register stages are differences and position*velocity, the three gain
// multiplies, clamp, knot lookup, interpolation multiply, position product
// and the saturating add into the output register. A stalled result holds
// the output register while earlier stages keep filling any empty slots, so
// in_stall rises only once every stage holds an item. Registers are written
// through cfg_write, cfg_index and cfg_data; the user must write them only
// while the core is idle, which the core does not enforce. They come out of
// reset as inv_position_damping 10.0, speed_gain 1.0, position_margin 410
// and speed_offset 0. The sigmoid knot tables are constants built at
// elaboration from SIGMOID_SEGMENTS; there is no clearing pass.
module sigmoid_joint_limit_weight_core #(
  parameter int SIGMOID_SEGMENTS = sjlw_pkg::SIGMOID_SEGMENTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sjlw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sjlw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [15:0]               joint_position,
  input  wire logic signed [15:0]               joint_velocity,
  input  wire logic signed [15:0]               lower_limit,
  input  wire logic signed [15:0]               upper_limit,
  input  wire logic                             last_joint,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [15:0]                           weight,
  output logic                                  weight_last
);
  import sjlw_pkg::*;

  localparam int STAGES = 7;

  logic [15:0]        inv_position_damping;
  logic [15:0]        speed_gain;
  logic [14:0]        position_margin;
  logic signed [15:0] speed_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_position_damping <= INV_DAMP_RESET;
      speed_gain           <= SPEED_GAIN_RESET;
      position_margin      <= MARGIN_RESET;
      speed_offset         <= SPEED_OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        CFG_INV_DAMP:     inv_position_damping <= cfg_data;
        CFG_SPEED_GAIN:   speed_gain           <= cfg_data;
        CFG_MARGIN:       position_margin      <= cfg_data[14:0];
        CFG_SPEED_OFFSET: speed_offset         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Pipe control: a stage loads when it is empty or its content moves on.
  logic [STAGES:1] vld;
  logic [STAGES:1] ready;
  logic [STAGES:1] last_pipe;
  pipe_en_t        en;

  always_comb begin
    ready[STAGES] = !vld[STAGES] || !out_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign en = '{s1: ready[1], s2: ready[2], s3: ready[3], s4: ready[4],
                s5: ready[5], s6: ready[6], s7: ready[7]};

  assign in_stall    = !ready[1];
  assign out_valid   = vld[STAGES];
  assign weight_last = last_pipe[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      last_pipe[1] <= last_joint;
    end
    for (int k = 2; k <= STAGES; k++) begin
      if (ready[k]) begin
        last_pipe[k] <= last_pipe[k-1];
      end
    end
  end

  logic [16:0] u_rise;
  logic [16:0] u_fall;
  logic [16:0] u_speed;

  sjlw_arg u_arg (
    .clk                  (clk),
    .en                   (en),
    .joint_position       (joint_position),
    .joint_velocity       (joint_velocity),
    .lower_limit          (lower_limit),
    .upper_limit          (upper_limit),
    .inv_position_damping (inv_position_damping),
    .speed_gain           (speed_gain),
    .position_margin      (position_margin),
    .speed_offset         (speed_offset),
    .u_rise               (u_rise),
    .u_fall               (u_fall),
    .u_speed              (u_speed)
  );

  logic [15:0] sig_rise;
  logic [15:0] sig_fall;
  logic [15:0] sig_speed;

  sjlw_sigmoid #(.SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)) u_sig_rise (
    .clk (clk),
    .en  (en),
    .u   (u_rise),
    .s   (sig_rise)
  );

  sjlw_sigmoid #(.SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)) u_sig_fall (
    .clk (clk),
    .en  (en),
    .u   (u_fall),
    .s   (sig_fall)
  );

  sjlw_sigmoid #(.SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)) u_sig_speed (
    .clk (clk),
    .en  (en),
    .u   (u_speed),
    .s   (sig_speed)
  );

  logic [15:0] pos_prod;
  logic [15:0] speed_d;
  logic [31:0] ab;
  logic [16:0] w_sum;

  assign ab    = 32'(sig_rise) * 32'(sig_fall) + 32'd16384;
  assign w_sum = 17'(pos_prod) + 17'(speed_d);

  always_ff @(posedge clk) begin
    if (en.s6) begin
      pos_prod <= 16'(ab >> 15);
      speed_d  <= sig_speed;
    end
    if (en.s7) begin
      weight <= (w_sum > 17'(ONE_Q15)) ? ONE_Q15 : w_sum[15:0];
    end
  end

  // Input is held off only when no stage has a free slot.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("in_stall raised while a pipe stage is empty");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !vld[STAGES-1]) |=> !out_valid)
    else $error("result repeated after it was taken");

  // Saturation keeps the weight at or below 1.0.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weight <= ONE_Q15))
    else $error("weight above 1.0");

endmodule

`default_nettype wire

FILE: bench/joint_weight_checker.sv
`timescale 1ns / 1ps
// Checker for the joint-limit weight core: predicts each weight and compares it.
module joint_weight_checker #(
  parameter int SEGS = sjlw_pkg::SIGMOID_SEGMENTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sjlw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sjlw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire logic signed [15:0]               joint_position,
  input  wire logic signed [15:0]               joint_velocity,
  input  wire logic signed [15:0]               lower_limit,
  input  wire logic signed [15:0]               upper_limit,
  input  wire logic                             last_joint,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [15:0]                      weight,
  input  wire logic                             weight_last,
  output int                                    mismatches,
  output int                                    outstanding,
  output int                                    weights_checked
);

  typedef struct {
    logic [15:0] weight;
    logic        last;
  } weight_item_t;

  weight_item_t expected_weights[$];
  weight_item_t head;

  logic [15:0]        inv_damp;
  logic [15:0]        speed_gain;
  logic [14:0]        margin;
  logic signed [15:0] speed_offset;

  longint knot_tab [0:SEGS];

  // e^-(num/den) in Q30: series of e^-(x/16), then squared four times
  function automatic longint exp_neg_q30(longint num, longint den);
    longint u;
    longint term;
    longint acc;
    u    = (num <<< 30) / (16 * den);
    term = longint'(1) <<< 30;
    acc  = term;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * u) >>> 30) / n;
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (int n = 0; n < 4; n++) begin
      acc = (acc * acc) >>> 30;
    end
    return acc;
  endfunction

  function automatic longint knot_value(int k);
    longint diff;
    longint span;
    longint den;
    longint p;
    diff = 16 * longint'(k) - 8 * longint'(SEGS);
    span = (diff < 0) ? -diff : diff;
    den  = (longint'(1) <<< 30) + exp_neg_q30(span, SEGS);
    p    = ((longint'(1) <<< 45) + den / 2) / den;
    return (diff < 0) ? 32768 - p : p;
  endfunction

  initial begin
    for (int k = 0; k <= SEGS; k++) begin
      knot_tab[k] = knot_value(k);
    end
  end

  // piecewise-linear sigmoid, argument in Q12 saturated at +-8
  function automatic longint sigmoid_q15(longint x);
    longint xc;
    longint p;
    longint seg;
    longint frac;
    xc = x;
    if (xc < -32768) xc = -32768;
    if (xc > 32768) xc = 32768;
    p    = (xc + 32768) * SEGS;
    seg  = p >>> 16;
    frac = p & 65535;
    if (seg >= SEGS) return knot_tab[SEGS];
    return knot_tab[seg] + (((knot_tab[seg + 1] - knot_tab[seg]) * frac + 32768) >>> 16);
  endfunction

  function automatic logic [15:0] predict_weight(logic signed [15:0] q, logic signed [15:0] v,
                                                 logic signed [15:0] lo, logic signed [15:0] hi);
    longint qq, vv, ll, hh;
    longint mm, inv, gain, off;
    longint rise, fall, spd, prod, w;
    qq   = q;
    vv   = v;
    ll   = lo;
    hh   = hi;
    mm   = margin;
    inv  = inv_damp;
    gain = speed_gain;
    off  = speed_offset;
    rise = sigmoid_q15(((qq - ll - mm) * inv) >>> 8);
    fall = sigmoid_q15(((hh - mm - qq) * inv) >>> 8);
    spd  = sigmoid_q15((-((qq * vv + off * 4096) * gain)) >>> 20);
    prod = (rise * fall + 16384) >>> 15;
    w    = prod + spd;
    if (w > 32768) w = 32768;
    return w[15:0];
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      inv_damp     = sjlw_pkg::INV_DAMP_RESET;
      speed_gain   = sjlw_pkg::SPEED_GAIN_RESET;
      margin       = sjlw_pkg::MARGIN_RESET;
      speed_offset = sjlw_pkg::SPEED_OFFSET_RESET;
      expected_weights.delete();
      mismatches      = 0;
      weights_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_weights.size() == 0) begin
          flag_mismatch("weight with no item outstanding", weight, 'x);
        end else begin
          head = expected_weights.pop_front();
          if (weight !== head.weight) flag_mismatch("weight", weight, head.weight);
          if (weight_last !== head.last) flag_mismatch("weight_last", weight_last, head.last);
          weights_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_weights.push_back('{predict_weight(joint_position, joint_velocity,
                                                    lower_limit, upper_limit), last_joint});
      end
      if (cfg_write) begin
        case (cfg_index)
          sjlw_pkg::CFG_INV_DAMP:     inv_damp = cfg_data;
          sjlw_pkg::CFG_SPEED_GAIN:   speed_gain = cfg_data;
          sjlw_pkg::CFG_MARGIN:       margin = cfg_data[14:0];
          sjlw_pkg::CFG_SPEED_OFFSET: speed_offset = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_weights.size();
  end

endmodule

FILE: bench/sigmoid_joint_limit_weight_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the joint-limit weight core: stimulus, register phases and verdict.
module sigmoid_joint_limit_weight_core_tb;

  localparam int LIMIT_CYCLES     = 500000;
  localparam int PHASES           = 10;
  localparam int ITEMS_PER_PHASE  = 110;
  localparam int SETTLE_CYCLES    = 12;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [sjlw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sjlw_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic signed [15:0]               joint_position;
  logic signed [15:0]               joint_velocity;
  logic signed [15:0]               lower_limit;
  logic signed [15:0]               upper_limit;
  logic                             last_joint;
  logic                             out_valid;
  logic                             out_stall;
  logic [15:0]                      weight;
  logic                             weight_last;

  int mismatches;
  int outstanding;
  int weights_checked;
  int cycle_count;
  int joints_sent;
  int settings_used;
  bit quiet;
  bit gaps_on;

  sigmoid_joint_limit_weight_core u_top (.*);

  joint_weight_checker u_checker (.*);

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles, %0d items outstanding", cycle_count, outstanding);
    $display("Regression FAIL");
    $finish;
  end

  // receiver backpressure: random stall bursts, with stalling switched on or off at random
  initial begin
    int cnt;
    bit stall_on;
    cnt       = 0;
    stall_on  = 1'b1;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cnt++;
      if (cnt % 100 == 0) stall_on = ($urandom_range(0, 3) != 0);
      if (quiet || !stall_on || $urandom_range(0, 6) != 0) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end
    end
  end

  function automatic logic signed [15:0] sat16(int x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return x[15:0];
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_joint(logic signed [15:0] q, logic signed [15:0] v,
                            logic signed [15:0] lo, logic signed [15:0] hi, logic last);
    if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    joint_position = q;
    joint_velocity = v;
    lower_limit    = lo;
    upper_limit    = hi;
    last_joint     = last;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    joints_sent++;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(sjlw_pkg::reg_index_t idx, logic [15:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  task automatic program_regs(logic [15:0] inv, logic [15:0] gain, logic [14:0] marg,
                              logic [15:0] off);
    write_reg(sjlw_pkg::CFG_INV_DAMP, inv);
    write_reg(sjlw_pkg::CFG_SPEED_GAIN, gain);
    write_reg(sjlw_pkg::CFG_MARGIN, {1'b0, marg});
    write_reg(sjlw_pkg::CFG_SPEED_OFFSET, off);
    cfg_write = 1'b0;
    settings_used++;
  endtask

  // mostly plausible joints near their limits, the rest raw noise
  task automatic random_joint(output logic signed [15:0] q, output logic signed [15:0] v,
                              output logic signed [15:0] lo, output logic signed [15:0] hi);
    int lo_i, hi_i, q_i;
    if ($urandom_range(0, 9) < 3) begin
      q  = $urandom;
      v  = $urandom;
      lo = $urandom;
      hi = $urandom;
    end else begin
      lo_i = int'($urandom_range(0, 40000)) - 32768;
      hi_i = lo_i + int'($urandom_range(0, 25000));
      if (hi_i > 32767) hi_i = 32767;
      case ($urandom_range(0, 2))
        0:       q_i = lo_i + int'($urandom_range(0, 6000)) - 3000;
        1:       q_i = hi_i + int'($urandom_range(0, 6000)) - 3000;
        default: q_i = lo_i + int'($urandom_range(0, hi_i - lo_i));
      endcase
      q  = sat16(q_i);
      lo = lo_i[15:0];
      hi = hi_i[15:0];
      if ($urandom_range(0, 4) == 0) begin
        v = $urandom;
      end else begin
        v = sat16(int'($urandom_range(0, 16384)) - 8192);
      end
    end
  endtask

  initial begin
    logic signed [15:0] q, v, lo, hi;
    logic [15:0] r_inv, r_gain, r_off;
    logic [14:0] r_marg;
    int left;

    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = sjlw_pkg::CFG_INV_DAMP;
    cfg_data       = '0;
    in_valid       = 1'b0;
    joint_position = '0;
    joint_velocity = '0;
    lower_limit    = '0;
    upper_limit    = '0;
    last_joint     = 1'b0;
    quiet          = 1'b0;
    gaps_on        = 1'b1;
    cycle_count    = 0;
    joints_sent    = 0;
    settings_used  = 1;
    left           = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed joints under the reset settings
    send_joint(0, 0, 0, 0, 1'b0);
    send_joint(410, 0, 0, 8192, 1'b0);               // rising sigmoid at its midpoint
    send_joint(7782, 0, -8192, 8192, 1'b1);          // falling sigmoid at its midpoint
    send_joint(32767, 32767, -32768, 32767, 1'b1);
    send_joint(-32768, -32768, -32768, -32768, 1'b0);
    send_joint(-32768, 32767, 32767, -32768, 1'b1);  // limits swapped, rising argument far below -8
    send_joint(0, 0, 100, -100, 1'b0);               // swapped and close
    send_joint(1000, 0, 1000, 1000, 1'b0);           // limits closer than the margin
    send_joint(4096, 4096, -16384, 16384, 1'b0);
    send_joint(4096, -4096, -16384, 16384, 1'b1);
    send_joint(3687, 0, 0, 16384, 1'b0);             // rising argument just past 8
    send_joint(3686, 0, 0, 16384, 1'b0);             // rising argument just under 8
    send_joint(-1, -1, -1, -1, 1'b1);
    send_joint(16384, 2048, 0, 17000, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: program_regs(16'hFFFF, 16'hFFFF, 15'h7FFF, 16'h7FFF);
        1: program_regs(16'h0000, 16'h0000, 15'h0000, 16'h8000);
        2: program_regs(sjlw_pkg::INV_DAMP_RESET, sjlw_pkg::SPEED_GAIN_RESET,
                        sjlw_pkg::MARGIN_RESET, sjlw_pkg::SPEED_OFFSET_RESET);
        3: program_regs(16'hFFFF, 16'h0000, 15'h7FFF, 16'h0000);
        default: begin
          r_inv  = $urandom_range(0, 1) ? 16'($urandom_range(128, 6000)) : 16'($urandom);
          r_gain = $urandom_range(0, 1) ? 16'($urandom_range(64, 2048)) : 16'($urandom);
          r_marg = $urandom_range(0, 1) ? 15'($urandom_range(0, 2000)) : 15'($urandom);
          r_off  = $urandom_range(0, 1) ? 16'(sat16(int'($urandom_range(0, 8192)) - 4096))
                                        : 16'($urandom);
          program_regs(r_inv, r_gain, r_marg, r_off);
        end
      endcase
      if (phase == PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        if (left == 0) left = $urandom_range(1, 7);
        left--;
        random_joint(q, v, lo, hi);
        send_joint(q, v, lo, hi, left == 0);
      end
    end

    drain_results();
    $display("Run covered %0d joint items and %0d checked weights", joints_sent,
             weights_checked);
    $display("across %0d register settings with random gaps and output stalls",
             settings_used);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
